// ===== rtl/core/bfdh_pkg.sv =====
// Package: shared constants and types for the Bloom filter block.
package bfdh_pkg;
  localparam int unsigned MAX_BITS_DEF   = 65536;
  localparam int unsigned MAX_HASHES_DEF = 16;
  localparam int unsigned BITCNT_W = 17;
  localparam int unsigned HASHCNT_W = 5;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned QDEPTH = 2;

  localparam logic [1:0] REG_BIT_COUNT  = 2'd0;
  localparam logic [1:0] REG_HASH_COUNT = 2'd1;
  localparam logic [1:0] REG_HASH_SALT  = 2'd2;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One classified item: everything the back end needs.
  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] h1;
    logic [KEY_W-1:0] h2;
  } job_t;
endpackage

// ===== rtl/core/bloom_filter_double_hash_top.sv =====
// Top level of the double-hash Bloom filter.
// Each item is an add or a query of a 64-bit key. The front end queues up
// to two items; the back end probes hash_count positions (clamped to
// MAX_HASHES), each by 64 steps of a bit-serial modulo, one bit-store
// access and one check, then finishes the item with a result state. The
// bit-serial modulo sets the pace. After reset a clearing pass writes
// every bit of the store to zero before the first item is taken; busy is high
// meanwhile. done pulses one cycle with maybe_present; it cannot be stalled.
module bloom_filter_double_hash_top #(
  parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_HASHES = bfdh_pkg::MAX_HASHES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode,
  input  logic signed [63:0]          key,
  output logic                        done,
  output logic                        maybe_present,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [bfdh_pkg::CFG_W-1:0]  cfg_data
);
  logic [bfdh_pkg::BITCNT_W-1:0]  bit_count;
  logic [bfdh_pkg::HASHCNT_W-1:0] hash_count;
  logic [63:0]                    hash_salt;
  logic                           full, job_valid, job_take, clearing;
  bfdh_pkg::job_t                 job;

  // Config registers; unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= bfdh_pkg::BITCNT_W'(65536);
      hash_count <= bfdh_pkg::HASHCNT_W'(7);
      hash_salt <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfdh_pkg::REG_BIT_COUNT:  bit_count <= cfg_data[bfdh_pkg::BITCNT_W-1:0];
        bfdh_pkg::REG_HASH_COUNT: hash_count <= cfg_data[bfdh_pkg::HASHCNT_W-1:0];
        bfdh_pkg::REG_HASH_SALT:  hash_salt <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold items off while the store is being cleared or the queue is full.
  assign busy = full || clearing;

  bfdh_front u_front (
    .clk(clk), .rst(rst), .start(start && !clearing), .opcode(opcode),
    .key(key), .salt(hash_salt), .full(full), .job_valid(job_valid),
    .job(job), .job_take(job_take)
  );

  bfdh_back #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_back (
    .clk(clk), .rst(rst), .bit_count(bit_count), .hash_count(hash_count),
    .job_valid(job_valid), .job(job), .job_take(job_take), .done(done),
    .maybe_present(maybe_present), .clearing(clearing)
  );
endmodule

// ===== rtl/core/bfdh_ram.sv =====
// Generic single-port RAM with registered read.
module bfdh_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/bfdh_front.sv =====
// Front end: takes items, forms both hashes, queues jobs for the back end.
module bfdh_front #(
  parameter int unsigned DEPTH = bfdh_pkg::QDEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      opcode,
  input  logic [bfdh_pkg::KEY_W-1:0] key,
  input  logic [bfdh_pkg::KEY_W-1:0] salt,
  output logic                      full,
  output logic                      job_valid,
  output bfdh_pkg::job_t            job,
  input  logic                      job_take
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  bfdh_pkg::job_t  q [DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [PW:0]     cnt;
  logic            push;

  assign full = (cnt == (PW+1)'(DEPTH));
  assign push = start && !full;
  assign job_valid = (cnt != '0);
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (job_take) begin
        rp <= (rp == PW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(job_take);
    end
    if (push) begin
      q[wp] <= '{opcode: opcode, h1: key, h2: key ^ salt};
    end
  end
endmodule

// ===== rtl/core/bfdh_back.sv =====
// Back end: per probe, a bit-serial 64-bit modulo and one bit-store access.
module bfdh_back #(
  parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_HASHES = bfdh_pkg::MAX_HASHES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bfdh_pkg::BITCNT_W-1:0] bit_count,
  input  logic [bfdh_pkg::HASHCNT_W-1:0] hash_count,
  input  logic                          job_valid,
  input  bfdh_pkg::job_t                job,
  output logic                          job_take,
  output logic                          done,
  output logic                          maybe_present,
  output logic                          clearing
);
  localparam int unsigned AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int unsigned MW = $clog2(MAX_BITS + 1);
  localparam int unsigned KW = $clog2(MAX_HASHES + 1);
  localparam int unsigned RW = MW + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_ACC, S_CHK, S_NEXT
  } state_t;

  state_t           state;
  logic [63:0]      pos, h2, divd;
  logic [RW-1:0]    rem;
  logic [MW-1:0]    modv;
  logic [KW-1:0]    kmax, pidx;
  logic [6:0]       bcnt;
  logic             op, all_set;
  logic [AW-1:0]    addr, clr_addr;
  logic             we, wbit, rbit;
  logic [RW-1:0]    rem_sh, rem_next;
  logic [MW-1:0]    modv_next;
  logic [KW-1:0]    kmax_next;

  // Clamp the configured counts.
  always_comb begin
    if (bit_count == '0) begin
      modv_next = MW'(1);
    end else if (32'(bit_count) > MAX_BITS) begin
      modv_next = MW'(MAX_BITS);
    end else begin
      modv_next = MW'(bit_count);
    end
    if (32'(hash_count) > MAX_HASHES) begin
      kmax_next = KW'(MAX_HASHES);
    end else begin
      kmax_next = KW'(hash_count);
    end
  end

  // One restoring division step per cycle, MSB first.
  assign rem_sh   = {rem[RW-2:0], divd[63]};
  assign rem_next = (rem_sh >= RW'(modv)) ? rem_sh - RW'(modv) : rem_sh;

  assign addr = (state == S_CLEAR) ? clr_addr : AW'(rem);
  assign we   = (state == S_CLEAR) || (state == S_ACC && op == bfdh_pkg::OP_ADD);
  assign wbit = (state != S_CLEAR);
  assign job_take = (state == S_IDLE) && job_valid;
  assign clearing = (state == S_CLEAR);

  bfdh_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(wbit), .rdata(rbit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      done <= 1'b0;
      maybe_present <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_BITS-1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            op <= job.opcode;
            pos <= job.h1;
            h2 <= job.h2;
            divd <= job.h1;
            modv <= modv_next;
            kmax <= kmax_next;
            pidx <= '0;
            all_set <= 1'b1;
            rem <= '0;
            bcnt <= '0;
            state <= (kmax_next == '0) ? S_NEXT : S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          divd <= {divd[62:0], 1'b0};
          bcnt <= bcnt + 1'b1;
          if (bcnt == 7'd63) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (op == bfdh_pkg::OP_QUERY && !rbit) begin
            all_set <= 1'b0;
          end
          pidx <= pidx + 1'b1;
          pos <= pos + h2;
          divd <= pos + h2;
          rem <= '0;
          bcnt <= '0;
          state <= (pidx + 1'b1 == kmax) ? S_NEXT : S_DIV;
        end
        S_NEXT: begin
          done <= 1'b1;
          maybe_present <= (op == bfdh_pkg::OP_QUERY) && all_set;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/bfdh_checker.sv =====
// Port-level checker for the Bloom filter top, with its bind.
module bfdh_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic maybe_present
);
  // A result never comes right after reset.
  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done) else $error("done right after reset");
  // Busy is high in the first cycle out of reset (store clearing).
  a_busy_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> busy) else $error("not busy after reset");
  // Results are single-cycle pulses.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  // Outputs are always known once out of reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({busy, done, maybe_present}))
    else $error("unknown output");
endmodule

bind bloom_filter_double_hash_top bfdh_checker u_bfdh_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .maybe_present(maybe_present)
);

// ===== dv/tb_bloom_filter_double_hash_top.sv =====
// Self-checking testbench for the double-hash Bloom filter top level.
module tb_bloom_filter_double_hash_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ARRAY_BITS = bfdh_pkg::MAX_BITS_DEF;
  localparam int unsigned PROBE_MAX  = bfdh_pkg::MAX_HASHES_DEF;
  // Worst item: 16 probes plus overhead; used for the final wait before the summary.
  localparam int unsigned ITEM_LAT   = 66 * PROBE_MAX + 40;
  localparam longint      CYCLE_CAP  = 8000000;
  localparam int          N_RANDOM   = 1150;
  localparam logic [1:0]  REG_UNUSED = 2'd3;

  typedef struct {
    logic                       op;
    logic [bfdh_pkg::KEY_W-1:0] key;
  } lookup_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          opcode;
  logic signed [63:0]            key;
  logic                          done;
  logic                          maybe_present;
  logic                          cfg_we;
  logic [1:0]                    cfg_index;
  logic [bfdh_pkg::CFG_W-1:0]    cfg_data;

  bloom_filter_double_hash_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .key(key),
    .done(done), .maybe_present(maybe_present),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the filter: bit array plus the three registers.
  bit                                shadow_bits [ARRAY_BITS];
  logic [bfdh_pkg::BITCNT_W-1:0]     shadow_bit_count;
  logic [bfdh_pkg::HASHCNT_W-1:0]    shadow_hash_count;
  logic [63:0]                       shadow_salt;

  lookup_t pending_items [$];   // waiting for the driver
  bit      expected_hits [$];   // predicted maybe_present, oldest first
  int      n_queued, n_accepted, n_checked, n_errors;
  int      n_adds, n_queries, n_hits, n_phases;
  bit      gaps_on;             // each phase draws gaps or back-to-back
  longint  cycle_count;

  // Probe all positions of a key; set them for an add, test them for a query.
  function automatic bit probe_filter(logic op, logic [63:0] k);
    longint unsigned h2, modulus, probes, pos;
    bit all_set;
    h2 = k ^ shadow_salt;
    modulus = (shadow_bit_count == 0) ? 1 : longint'(shadow_bit_count);
    if (modulus > ARRAY_BITS) modulus = ARRAY_BITS;
    probes = (shadow_hash_count > PROBE_MAX) ? PROBE_MAX : shadow_hash_count;
    all_set = 1'b1;
    for (longint unsigned i = 0; i < probes; i++) begin
      pos = (k + i * h2) % modulus;
      if (op == bfdh_pkg::OP_ADD) shadow_bits[pos] = 1'b1;
      else if (!shadow_bits[pos]) all_set = 1'b0;
    end
    return (op == bfdh_pkg::OP_QUERY) && all_set;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: a new item may be presented in the same edge the last one is taken,
  // so start only drops when a gap is drawn or the queue runs dry.
  int gap_left;
  always @(posedge clk) begin
    lookup_t nxt;
    if (rst) begin
      start    <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        start  <= 1'b1;
        opcode <= nxt.op;
        key    <= nxt.key;
        gap_left = gaps_on ? $urandom_range(0, 12) : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: track register writes, check results, then predict new items.
  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          bfdh_pkg::REG_BIT_COUNT:  shadow_bit_count  = cfg_data[bfdh_pkg::BITCNT_W-1:0];
          bfdh_pkg::REG_HASH_COUNT: shadow_hash_count = cfg_data[bfdh_pkg::HASHCNT_W-1:0];
          bfdh_pkg::REG_HASH_SALT:  shadow_salt       = cfg_data;
          default: ;  // unknown index is ignored
        endcase
      end
      if (done) begin
        if (expected_hits.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected result maybe_present=%0b", maybe_present);
        end else begin
          want = expected_hits.pop_front();
          n_checked++;
          if (maybe_present !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result %0d maybe_present exp %0b got %0b",
                       n_checked, want, maybe_present);
          end
        end
      end
      if (start && !busy) begin
        want = probe_filter(opcode, key);
        expected_hits.push_back(want);
        n_accepted++;
        if (opcode == bfdh_pkg::OP_ADD) n_adds++;
        else begin
          n_queries++;
          if (want) n_hits++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("bloom_filter_double_hash_top verification failed");
      $finish;
    end
  end

  function automatic void queue_item(logic op, logic [63:0] k);
    lookup_t it;
    it.op  = op;
    it.key = k;
    pending_items.push_back(it);
    n_queued++;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Block idle: every item taken and answered, front end released.
  task automatic drain();
    while (n_accepted != n_queued || expected_hits.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random phase: registers, then mostly add-then-query traffic on a key pool.
  task automatic random_phase(int n_items);
    logic [63:0] pool [$];
    logic [63:0] v, k;
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       v = 0;
      1:       v = 65536;
      2:       v = $urandom_range(65537, 131071);
      3, 4, 5: v = $urandom_range(1, 64);
      default: v = $urandom_range(1, 65536);
    endcase
    write_reg(bfdh_pkg::REG_BIT_COUNT, {$urandom(), $urandom()} & ~64'h1FFFF | v);
    sel = $urandom_range(0, 9);
    case (sel)
      0:       v = 0;
      1:       v = 16;
      2:       v = $urandom_range(17, 31);
      default: v = $urandom_range(1, 8);
    endcase
    write_reg(bfdh_pkg::REG_HASH_COUNT, {$urandom(), $urandom()} & ~64'h1F | v);
    sel = $urandom_range(0, 3);
    write_reg(bfdh_pkg::REG_HASH_SALT, sel == 0 ? 64'd0 : sel == 1 ? '1 : rand_key());
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, rand_key());
    gaps_on = $urandom_range(0, 2) != 0;
    n_phases++;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4 || pool.size() == 0) begin
        k = rand_key();
        pool.push_back(k);
        queue_item(bfdh_pkg::OP_ADD, k);
      end else if (sel < 8) begin
        queue_item(bfdh_pkg::OP_QUERY, pool[$urandom_range(0, pool.size() - 1)]);
      end else begin
        queue_item(bfdh_pkg::OP_QUERY, rand_key());
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; opcode = bfdh_pkg::OP_ADD; key = '0;
    cfg_we = 1'b0; cfg_index = bfdh_pkg::REG_BIT_COUNT; cfg_data = '0;
    shadow_bit_count = 17'd65536; shadow_hash_count = 5'd7; shadow_salt = '0;
    foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
    n_queued = 0; n_accepted = 0; n_checked = 0; n_errors = 0;
    n_adds = 0; n_queries = 0; n_hits = 0; n_phases = 0;
    cycle_count = 0; gaps_on = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);   // clearing pass

    // Directed: reset registers, extreme keys, both operations.
    queue_item(bfdh_pkg::OP_QUERY, 64'd0);
    queue_item(bfdh_pkg::OP_ADD, 64'd0);
    queue_item(bfdh_pkg::OP_QUERY, 64'd0);
    queue_item(bfdh_pkg::OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_item(bfdh_pkg::OP_ADD, 64'h8000_0000_0000_0000);
    queue_item(bfdh_pkg::OP_QUERY, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_item(bfdh_pkg::OP_QUERY, 64'h8000_0000_0000_0000);
    queue_item(bfdh_pkg::OP_QUERY, '1);
    drain();
    // Zero bit count acts as one bit; all-ones salt; max probes clamp.
    write_reg(bfdh_pkg::REG_BIT_COUNT, 64'd0);
    write_reg(bfdh_pkg::REG_HASH_COUNT, 64'd31);
    write_reg(bfdh_pkg::REG_HASH_SALT, '1);
    queue_item(bfdh_pkg::OP_QUERY, 64'h1234_5678_9ABC_DEF0);
    queue_item(bfdh_pkg::OP_ADD, '1);
    queue_item(bfdh_pkg::OP_QUERY, 64'h5555_AAAA_5555_AAAA);
    drain();
    // Oversize bit count saturates; array survives register changes.
    write_reg(bfdh_pkg::REG_BIT_COUNT, 64'h1FFFF);
    write_reg(bfdh_pkg::REG_HASH_COUNT, 64'd16);
    write_reg(bfdh_pkg::REG_HASH_SALT, 64'hA5A5_5A5A_0F0F_F0F0);
    write_reg(REG_UNUSED, '1);   // unknown index, no effect
    queue_item(bfdh_pkg::OP_QUERY, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_item(bfdh_pkg::OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_item(bfdh_pkg::OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_item(bfdh_pkg::OP_QUERY, 64'h5555_5555_5555_5555);
    drain();
    // Zero probes: add does nothing, every query answers present.
    write_reg(bfdh_pkg::REG_HASH_COUNT, 64'd0);
    queue_item(bfdh_pkg::OP_ADD, 64'hDEAD_BEEF_0000_0001);
    queue_item(bfdh_pkg::OP_QUERY, 64'h0BAD_F00D_0000_0002);
    queue_item(bfdh_pkg::OP_QUERY, '1);
    drain();
    write_reg(bfdh_pkg::REG_BIT_COUNT, 64'd1);
    write_reg(bfdh_pkg::REG_HASH_COUNT, 64'd1);
    queue_item(bfdh_pkg::OP_QUERY, 64'd77);
    drain();

    while (n_queued < N_RANDOM + 20) random_phase($urandom_range(20, 60));

    repeat (ITEM_LAT) @(posedge clk);
    $display("Covered %0d items over %0d random register settings: %0d adds, %0d queries",
             n_accepted, n_phases, n_adds, n_queries);
    $display("%0d queries reported maybe-present; %0d results checked, %0d mismatches",
             n_hits, n_checked, n_errors);
    if (n_errors == 0 && expected_hits.size() == 0) begin
      $display("bloom_filter_double_hash_top verification clean");
    end else begin
      $display("bloom_filter_double_hash_top verification failed");
    end
    $finish;
  end
endmodule
